@@ sv/sdvp_pkg.sv @@
// Shared types, constants and lookup tables for the distance volume and pan block.
`default_nettype none

package sdvp_pkg;

   // Field widths fixed by the event format
   localparam int unsigned VOL_W   = 8;
   localparam int unsigned OFS_W   = 8;
   localparam int unsigned PAN_W   = 16;
   localparam int unsigned SQ_W    = 2 * OFS_W - 1;   // 128*128 fits in 15 bits
   localparam int unsigned DEN_W   = 16;              // sum of squares plus 8
   localparam int unsigned VDIV_W  = VOL_W + 3;       // (vol << 8) >> 5
   localparam int unsigned RDIV_W  = OFS_W + 11;      // |lat| << 11
   localparam int unsigned RREM_W  = OFS_W;           // remainder below |fwd|
   localparam int unsigned NUM_POS = 8;
   localparam int unsigned POS_W   = $clog2(NUM_POS);

   localparam logic [DEN_W-1:0] DEN_BIAS = 16'h0008;

   // Quotient bits retired in each divider stage
   localparam int unsigned DIV_STAGES = 5;
   localparam int unsigned RAT_STEPS [DIV_STAGES] = '{4, 4, 4, 4, 3};
   localparam int unsigned VOL_STEPS [DIV_STAGES] = '{3, 2, 2, 2, 2};

   // Pan words for the special cases
   localparam logic [PAN_W-1:0] PAN_CENTER     = 16'h8000;
   localparam logic [PAN_W-1:0] PAN_FAR_LEFT   = 16'h0800;
   localparam logic [PAN_W-1:0] PAN_FAR_RIGHT  = 16'hf800;

   // Descending ratio thresholds; the last one is zero
   localparam logic [PAN_W-1:0] THRESH [NUM_POS] = '{
      16'h25a0, 16'h11f0, 16'h0b00, 16'h0730,
      16'h0490, 16'h0290, 16'h00d0, 16'h0000
   };

   localparam logic [PAN_W-1:0] PAN_LEFT [NUM_POS] = '{
      16'h0800, 16'h1700, 16'h2600, 16'h3500,
      16'h4400, 16'h5300, 16'h6200, 16'h7100
   };

   localparam logic [PAN_W-1:0] PAN_RIGHT [NUM_POS] = '{
      16'hf800, 16'he900, 16'hda00, 16'hcb00,
      16'hbc00, 16'had00, 16'h9e00, 16'h8f00
   };

   // Working set of the two long divisions as it moves down the pipe
   typedef struct packed {
      logic [VDIV_W-1:0] vol_rq;    // dividend bits shifting out, quotient in
      logic [DEN_W-1:0]  vol_rem;
      logic [DEN_W-1:0]  denom;
      logic [RDIV_W-1:0] rat_rq;
      logic [RREM_W-1:0] rat_rem;
      logic [OFS_W-1:0]  afwd;
      logic              lat_zero;
      logic              fwd_zero;
      logic              lat_neg;
   } div_type;

endpackage

`default_nettype wire

@@ sv/sdvp_req_if.sv @@
// Input channel carrying one sound event per beat.
`default_nettype none

interface sdvp_req_if;
   logic                              valid;
   logic                              ready;
   logic        [sdvp_pkg::VOL_W-1:0] base_volume;
   logic signed [sdvp_pkg::OFS_W-1:0] lateral_offset;
   logic signed [sdvp_pkg::OFS_W-1:0] forward_offset;

   modport source (output valid, base_volume, lateral_offset, forward_offset,
                   input ready);
   modport sink   (input valid, base_volume, lateral_offset, forward_offset,
                   output ready);
endinterface

`default_nettype wire

@@ sv/sdvp_rsp_if.sv @@
// Result channel carrying attenuated volume and pan word per beat.
`default_nettype none

interface sdvp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sdvp_pkg::VOL_W-1:0]  attenuated_volume;
   logic [sdvp_pkg::PAN_W-1:0]  pan_word;

   modport source (output valid, attenuated_volume, pan_word, input ready);
   modport sink   (input valid, attenuated_volume, pan_word, output ready);
endinterface

`default_nettype wire

@@ sv/sdvp_front.sv @@
// Front end: magnitudes, squares and attenuation divisor over three stages.
`default_nettype none

module sdvp_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  wire        [sdvp_pkg::VOL_W-1:0]  in_volume,
   input  wire signed [sdvp_pkg::OFS_W-1:0]  in_lat,
   input  wire signed [sdvp_pkg::OFS_W-1:0]  in_fwd,
   output logic                              out_valid,
   input  wire                               out_ready,
   output sdvp_pkg::div_type                 out_data
);

   // stage 1: magnitudes and side flags
   logic                       s1_v_ff, s1_v_in;
   logic [sdvp_pkg::VOL_W-1:0] s1_vol_ff;
   logic [sdvp_pkg::OFS_W-1:0] s1_alat_ff, s1_afwd_ff;
   logic                       s1_lz_ff, s1_fz_ff, s1_neg_ff;
   // stage 2: squares
   logic                       s2_v_ff, s2_v_in;
   logic [sdvp_pkg::VOL_W-1:0] s2_vol_ff;
   logic [sdvp_pkg::OFS_W-1:0] s2_alat_ff, s2_afwd_ff;
   logic [sdvp_pkg::SQ_W-1:0]  s2_sqlat_ff, s2_sqfwd_ff;
   logic                       s2_lz_ff, s2_fz_ff, s2_neg_ff;
   // stage 3: divisor and division start values
   logic                       s3_v_ff, s3_v_in;
   sdvp_pkg::div_type          s3_data_ff, s3_data_in;

   logic s1_ready, s2_ready, s3_ready;
   logic [sdvp_pkg::OFS_W-1:0] alat, afwd;
   logic [2*sdvp_pkg::OFS_W-1:0] sqlat, sqfwd;

   // a stage takes a beat when empty or when it hands its own beat on
   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   // two's complement magnitude; -128 maps to 128 unsigned
   assign alat = in_lat[sdvp_pkg::OFS_W-1] ? (~in_lat + 1'b1) : in_lat;
   assign afwd = in_fwd[sdvp_pkg::OFS_W-1] ? (~in_fwd + 1'b1) : in_fwd;

   assign sqlat = s1_alat_ff * s1_alat_ff;
   assign sqfwd = s1_afwd_ff * s1_afwd_ff;

   // divisor and dividends for the two long divisions
   always_comb begin
      s3_data_in          = '0;
      s3_data_in.denom    = sdvp_pkg::DEN_W'(s2_sqlat_ff) + sdvp_pkg::DEN_W'(s2_sqfwd_ff)
                            + sdvp_pkg::DEN_BIAS;
      s3_data_in.vol_rq   = {s2_vol_ff, 3'b000};
      s3_data_in.rat_rq   = {s2_alat_ff, 11'b0};
      s3_data_in.afwd     = s2_afwd_ff;
      s3_data_in.lat_zero = s2_lz_ff;
      s3_data_in.fwd_zero = s2_fz_ff;
      s3_data_in.lat_neg  = s2_neg_ff;
   end

   assign s1_v_in = s1_ready ? in_valid : s1_v_ff;
   assign s2_v_in = s2_ready ? s1_v_ff  : s2_v_ff;
   assign s3_v_in = s3_ready ? s2_v_ff  : s3_v_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_vol_ff  <= in_volume;
         s1_alat_ff <= alat;
         s1_afwd_ff <= afwd;
         s1_lz_ff   <= (in_lat == '0);
         s1_fz_ff   <= (in_fwd == '0);
         s1_neg_ff  <= in_lat[sdvp_pkg::OFS_W-1];
      end
      if (s2_ready && s1_v_ff) begin
         s2_vol_ff   <= s1_vol_ff;
         s2_alat_ff  <= s1_alat_ff;
         s2_afwd_ff  <= s1_afwd_ff;
         s2_sqlat_ff <= sqlat[sdvp_pkg::SQ_W-1:0];
         s2_sqfwd_ff <= sqfwd[sdvp_pkg::SQ_W-1:0];
         s2_lz_ff    <= s1_lz_ff;
         s2_fz_ff    <= s1_fz_ff;
         s2_neg_ff   <= s1_neg_ff;
      end
      if (s3_ready && s2_v_ff) begin
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_v_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

@@ sv/sdvp_div_stage.sv @@
// One pipeline stage of the two restoring dividers, a few quotient bits each.
`default_nettype none

module sdvp_div_stage #(
   parameter int unsigned RatioSteps = sdvp_pkg::RAT_STEPS[0],
   parameter int unsigned VolSteps   = sdvp_pkg::VOL_STEPS[0]
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  sdvp_pkg::div_type  in_data,
   output logic               out_valid,
   input  wire                out_ready,
   output sdvp_pkg::div_type  out_data
);

   logic              v_ff, v_in;
   sdvp_pkg::div_type data_ff, data_in;

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   // shift-subtract steps: dividend MSB into remainder, quotient bit into LSB
   always_comb begin
      logic [sdvp_pkg::DEN_W:0]    vtrial;
      logic [sdvp_pkg::RREM_W:0]   rtrial;
      data_in = in_data;
      for (int i = 0; i < VolSteps; i++) begin
         vtrial         = {data_in.vol_rem, data_in.vol_rq[sdvp_pkg::VDIV_W-1]};
         data_in.vol_rq = {data_in.vol_rq[sdvp_pkg::VDIV_W-2:0], 1'b0};
         if (vtrial >= {1'b0, data_in.denom}) begin
            vtrial            = vtrial - {1'b0, data_in.denom};
            data_in.vol_rq[0] = 1'b1;
         end
         data_in.vol_rem = vtrial[sdvp_pkg::DEN_W-1:0];
      end
      for (int i = 0; i < RatioSteps; i++) begin
         rtrial         = {data_in.rat_rem, data_in.rat_rq[sdvp_pkg::RDIV_W-1]};
         data_in.rat_rq = {data_in.rat_rq[sdvp_pkg::RDIV_W-2:0], 1'b0};
         if (rtrial >= {1'b0, data_in.afwd}) begin
            rtrial            = rtrial - {1'b0, data_in.afwd};
            data_in.rat_rq[0] = 1'b1;
         end
         data_in.rat_rem = rtrial[sdvp_pkg::RREM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ sv/sdvp_pan.sv @@
// Output stage: threshold search, pan word selection and result register.
`default_nettype none

module sdvp_pan (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  sdvp_pkg::div_type           in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic [sdvp_pkg::VOL_W-1:0]  out_volume,
   output logic [sdvp_pkg::PAN_W-1:0]  out_pan
);

   logic                       v_ff, v_in;
   logic [sdvp_pkg::VOL_W-1:0] vol_ff;
   logic [sdvp_pkg::PAN_W-1:0] pan_ff, pan_in;
   logic [sdvp_pkg::PAN_W-1:0] ratio;
   logic [sdvp_pkg::POS_W-1:0] pos;

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   // ratio wraps to 16 bits
   assign ratio = in_data.rat_rq[sdvp_pkg::PAN_W-1:0];

   // first threshold met, scanning from the widest angle; the last is zero
   always_comb begin
      pos = sdvp_pkg::POS_W'(sdvp_pkg::NUM_POS - 1);
      for (int i = sdvp_pkg::NUM_POS - 2; i >= 0; i--) begin
         if (ratio >= sdvp_pkg::THRESH[i]) begin
            pos = sdvp_pkg::POS_W'(i);
         end
      end
   end

   // centered and straight-side sources bypass the search
   always_comb begin
      priority if (in_data.lat_zero) begin
         pan_in = sdvp_pkg::PAN_CENTER;
      end else if (in_data.fwd_zero) begin
         pan_in = in_data.lat_neg ? sdvp_pkg::PAN_FAR_LEFT : sdvp_pkg::PAN_FAR_RIGHT;
      end else begin
         pan_in = in_data.lat_neg ? sdvp_pkg::PAN_LEFT[pos] : sdvp_pkg::PAN_RIGHT[pos];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vol_ff <= in_data.vol_rq[sdvp_pkg::VOL_W-1:0];
         pan_ff <= pan_in;
      end
   end

   assign out_valid  = v_ff;
   assign out_volume = vol_ff;
   assign out_pan    = pan_ff;

endmodule

`default_nettype wire

@@ sv/sound_distance_volume_pan.sv @@
// Top level of the distance volume and pan block.
//
// Takes one sound event per beat and returns one result per event, in order.
// A new event is accepted every cycle while no back-pressure stalls it; the
// input beat reaches the result register through three front stages (magnitudes,
// squares, divisor), five divider stages that each retire up to four
// quotient bits of the pan ratio and two or three bits of the volume
// quotient, and one output stage holding the threshold search and the
// result register. Every stage has its own valid bit and holds its beat
// under back-pressure, so empty stages keep filling while a result waits;
// the input stalls only once every stage is occupied.
`default_nettype none

module sound_distance_volume_pan (
   input  wire        clock,
   input  wire        reset,
   sdvp_req_if.sink   req_chan,
   sdvp_rsp_if.source rsp_chan
);

   localparam int unsigned N = sdvp_pkg::DIV_STAGES;

   logic              dv_valid [N+1];
   logic              dv_ready [N+1];
   sdvp_pkg::div_type dv_data  [N+1];

   // magnitudes, squares and divisor
   sdvp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_volume (req_chan.base_volume),
      .in_lat    (req_chan.lateral_offset),
      .in_fwd    (req_chan.forward_offset),
      .out_valid (dv_valid[0]),
      .out_ready (dv_ready[0]),
      .out_data  (dv_data[0])
   );

   // divider chain
   for (genvar g = 0; g < N; g++) begin : g_div
      sdvp_div_stage #(
         .RatioSteps (sdvp_pkg::RAT_STEPS[g]),
         .VolSteps   (sdvp_pkg::VOL_STEPS[g])
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_ready  (dv_ready[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_ready (dv_ready[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   // pan selection and result register
   sdvp_pan u_pan (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv_valid[N]),
      .in_ready   (dv_ready[N]),
      .in_data    (dv_data[N]),
      .out_valid  (rsp_chan.valid),
      .out_ready  (rsp_chan.ready),
      .out_volume (rsp_chan.attenuated_volume),
      .out_pan    (rsp_chan.pan_word)
   );

endmodule

`default_nettype wire
